// File: src/cspb_pkg.sv
// Shared types, codes and constants of the cue sheet block parser.
`default_nettype none

package cspb_pkg;

   // Field lengths in bytes.
   localparam int CatalogLen  = 128;
   localparam int SheetResLen = 258;
   localparam int IsrcLen     = 12;
   localparam int TrkResLen   = 13;
   localparam int IdxResLen   = 3;
   localparam int OffsetLen   = 8;

   // Most results that one byte can cause.
   localparam int MaxResults  = 3;

   // Parse phases.
   typedef enum logic [4:0] {
      PH_CATALOG    = 5'd0,
      PH_LEADIN     = 5'd1,
      PH_CDFLAG     = 5'd2,
      PH_SHEET_RES  = 5'd3,
      PH_TRACKS     = 5'd4,
      PH_TRK_OFFSET = 5'd5,
      PH_TRK_NUMBER = 5'd6,
      PH_ISRC       = 5'd7,
      PH_TYPE       = 5'd8,
      PH_TRK_RES    = 5'd9,
      PH_POINTS     = 5'd10,
      PH_IDX_OFFSET = 5'd11,
      PH_IDX_NUMBER = 5'd12,
      PH_IDX_RES    = 5'd13,
      PH_DONE       = 5'd14
   } phase_type;

   // Result kinds.
   typedef enum logic [3:0] {
      K_CATALOG     = 4'd0,
      K_LEADIN      = 4'd1,
      K_CDFLAG      = 4'd2,
      K_TRACK_COUNT = 4'd3,
      K_TRK_OFFSET  = 4'd4,
      K_TRK_NUMBER  = 4'd5,
      K_ISRC        = 4'd6,
      K_TYPE        = 4'd7,
      K_PREEMPH     = 4'd8,
      K_INDEX_COUNT = 4'd9,
      K_IDX_OFFSET  = 4'd10,
      K_IDX_NUMBER  = 4'd11,
      K_TRACK_DONE  = 4'd12,
      K_SHEET_DONE  = 4'd13,
      K_ERROR       = 4'd14
   } kind_type;

   // One result item without its last-of-byte flag.
   typedef struct packed {
      kind_type    kind;
      logic [63:0] value;
      logic [7:0]  position;
   } res_type;

   // Builds one result item.
   function automatic res_type make_res(kind_type kind, logic [63:0] value,
                                        logic [7:0] position);
      res_type r;
      r.kind     = kind;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/cspb_parser.sv
// Parse state and the per-byte decode that yields up to three results.
`default_nettype none

module cspb_parser
   import cspb_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [7:0]                  data_byte,
   input  wire logic                        start_req,
   output res_type [MaxResults-1:0]         results,
   output logic [1:0]                       res_count
);

   phase_type   phase_ff, phase_in, base_phase;
   logic [8:0]  count_ff, count_in, base_count, count_val;
   logic [63:0] shift_ff, shift_in, base_shift, shift_val;
   logic [7:0]  ttotal_ff, ttotal_in, base_ttotal;
   logic [7:0]  tseen_ff, tseen_in, base_tseen, tseen_inc;
   logic [7:0]  ptotal_ff, ptotal_in, base_ptotal;
   logic [7:0]  pseen_ff, pseen_in, base_pseen, pseen_inc;
   logic [63:0] byte_val;

   // A start request puts the parser back at the first catalog byte first.
   always_comb begin
      base_phase  = start_req ? PH_CATALOG : phase_ff;
      base_count  = start_req ? 9'd0 : count_ff;
      base_shift  = start_req ? 64'd0 : shift_ff;
      base_ttotal = start_req ? 8'd0 : ttotal_ff;
      base_tseen  = start_req ? 8'd0 : tseen_ff;
      base_ptotal = start_req ? 8'd0 : ptotal_ff;
      base_pseen  = start_req ? 8'd0 : pseen_ff;
   end

   assign shift_val = {base_shift[55:0], data_byte};
   assign count_val = base_count + 9'd1;
   assign tseen_inc = base_tseen + 8'd1;
   assign pseen_inc = base_pseen + 8'd1;
   assign byte_val  = {56'd0, data_byte};

   // Decode of one byte: next state and the results it causes.
   always_comb begin
      phase_in  = base_phase;
      count_in  = count_val;
      shift_in  = shift_val;
      ttotal_in = base_ttotal;
      tseen_in  = base_tseen;
      ptotal_in = base_ptotal;
      pseen_in  = base_pseen;
      res_count = 2'd0;
      for (int i = 0; i < MaxResults; i++) begin
         results[i] = make_res(K_CATALOG, 64'd0, 8'd0);
      end

      unique case (base_phase)
         PH_CATALOG: begin
            results[0] = make_res(K_CATALOG, byte_val, base_count[7:0]);
            res_count  = 2'd1;
            if (count_val >= 9'(CatalogLen)) begin
               phase_in = PH_LEADIN;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_LEADIN: begin
            if (count_val >= 9'(OffsetLen)) begin
               results[0] = make_res(K_LEADIN, shift_val, 8'd0);
               res_count  = 2'd1;
               phase_in   = PH_CDFLAG;
               count_in   = '0;
               shift_in   = '0;
            end
         end
         PH_CDFLAG: begin
            results[0] = make_res(K_CDFLAG, {63'd0, data_byte[7]}, 8'd0);
            res_count  = 2'd1;
            phase_in   = PH_SHEET_RES;
            count_in   = '0;
            shift_in   = '0;
         end
         PH_SHEET_RES: begin
            if (count_val >= 9'(SheetResLen)) begin
               phase_in = PH_TRACKS;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_TRACKS: begin
            ttotal_in  = data_byte;
            tseen_in   = 8'd0;
            results[0] = make_res(K_TRACK_COUNT, byte_val, 8'd0);
            count_in   = '0;
            shift_in   = '0;
            // An empty sheet is finished on its track-count byte.
            if (data_byte == 8'd0) begin
               results[1] = make_res(K_SHEET_DONE, 64'd0, 8'd0);
               res_count  = 2'd2;
               phase_in   = PH_DONE;
            end else begin
               res_count = 2'd1;
               phase_in  = PH_TRK_OFFSET;
            end
         end
         PH_TRK_OFFSET: begin
            if (count_val >= 9'(OffsetLen)) begin
               results[0] = make_res(K_TRK_OFFSET, shift_val, base_tseen);
               res_count  = 2'd1;
               phase_in   = PH_TRK_NUMBER;
               count_in   = '0;
               shift_in   = '0;
            end
         end
         PH_TRK_NUMBER: begin
            results[0] = make_res(K_TRK_NUMBER, byte_val, base_tseen);
            res_count  = 2'd1;
            phase_in   = PH_ISRC;
            count_in   = '0;
            shift_in   = '0;
         end
         PH_ISRC: begin
            results[0] = make_res(K_ISRC, byte_val, base_count[7:0]);
            res_count  = 2'd1;
            if (count_val >= 9'(IsrcLen)) begin
               phase_in = PH_TYPE;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_TYPE: begin
            results[0] = make_res(K_TYPE, {63'd0, data_byte[7]}, base_tseen);
            results[1] = make_res(K_PREEMPH, {63'd0, data_byte[6]}, base_tseen);
            res_count  = 2'd2;
            phase_in   = PH_TRK_RES;
            count_in   = '0;
            shift_in   = '0;
         end
         PH_TRK_RES: begin
            if (count_val >= 9'(TrkResLen)) begin
               phase_in = PH_POINTS;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_POINTS: begin
            ptotal_in  = data_byte;
            pseen_in   = 8'd0;
            results[0] = make_res(K_INDEX_COUNT, byte_val, base_tseen);
            count_in   = '0;
            shift_in   = '0;
            // A track without index points closes on its count byte.
            if (data_byte == 8'd0) begin
               results[1] = make_res(K_TRACK_DONE, 64'd0, base_tseen);
               tseen_in   = tseen_inc;
               if (tseen_inc == base_ttotal) begin
                  results[2] = make_res(K_SHEET_DONE, 64'd0, 8'd0);
                  res_count  = 2'd3;
                  phase_in   = PH_DONE;
               end else begin
                  res_count = 2'd2;
                  phase_in  = PH_TRK_OFFSET;
               end
            end else begin
               res_count = 2'd1;
               phase_in  = PH_IDX_OFFSET;
            end
         end
         PH_IDX_OFFSET: begin
            if (count_val >= 9'(OffsetLen)) begin
               results[0] = make_res(K_IDX_OFFSET, shift_val, base_pseen);
               res_count  = 2'd1;
               phase_in   = PH_IDX_NUMBER;
               count_in   = '0;
               shift_in   = '0;
            end
         end
         PH_IDX_NUMBER: begin
            results[0] = make_res(K_IDX_NUMBER, byte_val, base_pseen);
            res_count  = 2'd1;
            phase_in   = PH_IDX_RES;
            count_in   = '0;
            shift_in   = '0;
         end
         PH_IDX_RES: begin
            // The last reserved byte of the last point closes the track.
            if (count_val >= 9'(IdxResLen)) begin
               pseen_in = pseen_inc;
               count_in = '0;
               shift_in = '0;
               if (pseen_inc == base_ptotal) begin
                  results[0] = make_res(K_TRACK_DONE, 64'd0, base_tseen);
                  tseen_in   = tseen_inc;
                  if (tseen_inc == base_ttotal) begin
                     results[1] = make_res(K_SHEET_DONE, 64'd0, 8'd0);
                     res_count  = 2'd2;
                     phase_in   = PH_DONE;
                  end else begin
                     res_count = 2'd1;
                     phase_in  = PH_TRK_OFFSET;
                  end
               end else begin
                  phase_in = PH_IDX_OFFSET;
               end
            end
         end
         default: begin
            // Done, or a phase code that is never reached: report an error.
            results[0] = make_res(K_ERROR, 64'd0, 8'd0);
            res_count  = 2'd1;
            phase_in   = PH_DONE;
            count_in   = '0;
            shift_in   = '0;
         end
      endcase
   end

   // Parse state registers, updated once per parsed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CATALOG;
         count_ff  <= '0;
         shift_ff  <= '0;
         ttotal_ff <= '0;
         tseen_ff  <= '0;
         ptotal_ff <= '0;
         pseen_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         ttotal_ff <= ttotal_in;
         tseen_ff  <= tseen_in;
         ptotal_ff <= ptotal_in;
         pseen_ff  <= pseen_in;
      end
   end

endmodule

`default_nettype wire

// File: src/cspb_result_buffer.sv
// Result register holding the items of one byte and handing them out in order.
`default_nettype none

module cspb_result_buffer
   import cspb_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire res_type [MaxResults-1:0]    load_results,
   input  wire logic [1:0]                  load_count,
   output logic                             free,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output res_type                          out_res,
   output logic                             out_last
);

   res_type [MaxResults-1:0] entry_ff;
   logic [1:0]               count_ff, count_in;
   logic [1:0]               head_ff, head_in;
   logic                     fire;

   assign out_valid = (count_ff != 2'd0);
   assign fire      = out_valid && out_ready;
   assign out_res   = entry_ff[head_ff];
   assign out_last  = (count_ff == 2'd1);

   // The register can take a new byte's items once the last one leaves.
   assign free = (count_ff == 2'd0) || ((count_ff == 2'd1) && fire);

   // Count of waiting items and read position.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      if (load) begin
         count_in = load_count;
         head_in  = 2'd0;
      end else if (fire) begin
         count_in = count_ff - 2'd1;
         head_in  = head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   // Item payloads need no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= load_results;
      end
   end

endmodule

`default_nettype wire

// File: src/cue_sheet_block_parser_top.sv
// Top level of the cue sheet block parser: input register, decode, result register.
// With the result register free, a byte's first item is offered once it has passed the
// input register and then the result register.
// Throughput: one byte per cycle while the result register is free; a byte with k results
// (k up to 3) holds the port; the single result register gives one item a cycle at most.
// Reset: synchronous, active high; the parser restarts at the first catalog byte
// with all counters and the shift register cleared, and both registers empty.
`default_nettype none

module cue_sheet_block_parser_top
   import cspb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_req,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_kind,
   output logic [63:0]      rsp_value,
   output logic [7:0]       rsp_position,
   output logic             rsp_last_of_byte
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               byte_ff;
   logic                     start_ff;
   logic                     advance;
   logic                     buf_free;
   res_type [MaxResults-1:0] results;
   logic [1:0]               res_count;
   res_type                  head_res;

   // A held byte moves on when its items fit, or when it causes none.
   assign advance   = in_valid_ff && (buf_free || (res_count == 2'd0));
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff  <= req_data_byte;
         start_ff <= req_start_req;
      end
   end

   cspb_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (byte_ff),
      .start_req (start_ff),
      .results   (results),
      .res_count (res_count)
   );

   cspb_result_buffer u_result_buffer (
      .clock        (clock),
      .reset        (reset),
      .load         (advance && (res_count != 2'd0)),
      .load_results (results),
      .load_count   (res_count),
      .free         (buf_free),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_res      (head_res),
      .out_last     (rsp_last_of_byte)
   );

   assign rsp_kind     = head_res.kind;
   assign rsp_value    = head_res.value;
   assign rsp_position = head_res.position;

endmodule

`default_nettype wire
